/* hdl/ile_pkg.sv */
// shared types, codes and field widths of the indexed list engine
`timescale 1ns / 1ps

package ile_pkg;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int FIDX_W  = 6;
    localparam int FCNT_W  = 7;
    localparam int STAT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND       = 3'd0,
        CMD_INSERT       = 3'd1,
        CMD_REMOVE_AT    = 3'd2,
        CMD_REMOVE_VALUE = 3'd3,
        CMD_GET          = 3'd4,
        CMD_SET          = 3'd5,
        CMD_FIRST_INDEX  = 3'd6,
        CMD_LAST_INDEX   = 3'd7
    } command_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } cell_op_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        cell_op_t op;
        logic     cmp_en;
    } cell_ctrl_t;

endpackage

/* hdl/ile_req_if.sv */
// command channel: valid, ready and the command word
`timescale 1ns / 1ps

interface ile_req_if;
    import ile_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] item_value;

    modport source (output valid, output command, output position, output item_value,
                    input ready);
    modport sink   (input valid, input command, input position, input item_value,
                    output ready);
endinterface

/* hdl/ile_rsp_if.sv */
// result channel: valid, ready and the result word
`timescale 1ns / 1ps

interface ile_rsp_if;
    import ile_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_value;
    logic [FIDX_W-1:0] found_index;
    logic              found;
    logic [FCNT_W-1:0] entry_count;
    logic [STAT_W-1:0] status;

    modport source (output valid, output read_value, output found_index, output found,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input read_value, input found_index, input found,
                    input entry_count, input status, output ready);
endinterface

/* hdl/ile_cell.sv */
// one list entry: holds a value, shifts with its neighbours and compares
`timescale 1ns / 1ps

module ile_cell #(
    parameter int IDX   = 0,
    parameter int VW    = 32,
    parameter int IDX_W = 6
) (
    input  logic              clk,
    input  ile_pkg::cell_ctrl_t ctrl,
    input  logic [IDX_W-1:0]  k,
    input  logic [VW-1:0]     wr_value,
    input  logic [VW-1:0]     cmp_value,
    input  logic [VW-1:0]     left_value,
    input  logic [VW-1:0]     right_value,
    output logic [VW-1:0]     value,
    output logic              match,
    output logic [VW-1:0]     read_part
);
    import ile_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [VW-1:0] data_reg;
    logic [VW-1:0] data_next;
    logic          match_reg;
    logic          match_next;
    logic          at_k;
    logic          above_k;

    assign at_k    = (MY_IDX == k);
    assign above_k = (MY_IDX > k);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            OP_WRITE:
            begin
                if (at_k)
                    data_next = wr_value;
            end
            OP_INSERT:
            begin
                if (above_k)
                    data_next = left_value;
                else if (at_k)
                    data_next = wr_value;
            end
            OP_REMOVE:
            begin
                if (above_k || at_k)
                    data_next = right_value;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    assign match_next = ctrl.cmp_en ? (data_reg == cmp_value) : match_reg;

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign value     = data_reg;
    assign match     = match_reg;
    assign read_part = at_k ? data_reg : '0;

endmodule

/* hdl/ile_pick.sv */
// picks the lowest or highest set match bit and encodes its index
`timescale 1ns / 1ps

module ile_pick #(
    parameter int N     = 64,
    parameter int IDX_W = 6
) (
    input  logic [N-1:0]     hits,
    input  logic             last,
    output logic             hit,
    output logic [IDX_W-1:0] index
);
    logic [N-1:0]     rev;
    logic [N-1:0]     src;
    logic [N-1:0]     iso;
    logic [IDX_W-1:0] raw;

    always_comb
    begin
        for (int i = 0; i < N; i++)
            rev[i] = hits[N-1-i];
    end

    assign src = last ? rev : hits;
    // lowest set bit kept alone by the two's complement trick
    assign iso = src & (~src + N'(1));

    always_comb
    begin
        raw = '0;
        for (int i = 0; i < N; i++)
        begin
            if (iso[i])
                raw = raw | IDX_W'(i);
        end
    end

    assign hit   = |hits;
    assign index = last ? (IDX_W'(N - 1) - raw) : raw;

endmodule

/* hdl/indexed_list_engine.sv */
// top level: ordered list of values kept in a chain of register cells
//
// Commands arrive as words on the req channel (command, position, item_value)
// and each one gives exactly one result word on the rsp channel (read_value,
// found_index, found, entry_count, status). A word is taken when valid and
// ready are both high at a rising edge of clk.
// Every entry sits in its own cell. On acceptance each cell compares its
// entry with the value; in the next cycle the match bits are reduced to the
// first or last hit, the command is decoded and all cells shift, write or
// hold together, and the result is loaded into the output register.
// A new command is taken only once the previous one has passed its execute
// cycle, since the compare register in the cells is followed by the match
// pick and shift cycle.
// Reset (rst_n low) empties the list and the output register; cell contents
// are left as they are and are never read before being written.
// A stalled receiver holds the result word in place; the next command is
// taken only in a cycle in which the output register is empty or drained.
`timescale 1ns / 1ps

module indexed_list_engine #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    ile_req_if.sink    req,
    ile_rsp_if.source  rsp
);
    import ile_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int VI_N  = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
    localparam int FI_N  = (IDX_W < FIDX_W) ? IDX_W : FIDX_W;
    localparam int FC_N  = (CNT_W < FCNT_W) ? CNT_W : FCNT_W;
    localparam int PK_N  = (IDX_W < POS_W) ? IDX_W : POS_W;

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic [CMD_W-1:0]       cmd_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [VALUE_WIDTH-1:0] val_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] rv_reg;
    logic [FIDX_W-1:0] fi_reg;
    logic              fd_reg;
    logic [FCNT_W-1:0] ec_reg;
    logic [STAT_W-1:0] st_reg;

    logic                   accept;
    logic                   load;
    logic [VALUE_WIDTH-1:0] in_val;
    cell_ctrl_t             ctrl;
    cell_op_t               dec_op;
    logic [IDX_W-1:0]       k;
    logic [IDX_W-1:0]       pos_k;
    logic [IDX_W-1:0]       cnt_k;

    logic [VALUE_WIDTH-1:0] cell_val  [CAPACITY];
    logic [VALUE_WIDTH-1:0] cell_rd   [CAPACITY];
    logic [CAPACITY-1:0]    cell_match;
    logic [CAPACITY-1:0]    live;
    logic [VALUE_WIDTH-1:0] read_all;

    logic             pick_hit;
    logic [IDX_W-1:0] pick_idx;

    status_t           dec_st;
    logic              dec_hit;
    logic [DATA_W-1:0] dec_rv;
    logic [FIDX_W-1:0] dec_fi;
    logic [FCNT_W-1:0] dec_ec;

    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic             full;

    // value masked to the entry width
    always_comb
    begin
        in_val = '0;
        for (int b = 0; b < VI_N; b++)
            in_val[b] = req.item_value[b];
    end

    always_comb
    begin
        pos_k = '0;
        for (int b = 0; b < PK_N; b++)
            pos_k[b] = pos_reg[b];
    end

    assign cnt_k = cnt_reg[IDX_W-1:0];
    assign pos_x = CMP_W'(pos_reg);
    assign cnt_x = CMP_W'(cnt_reg);
    assign full  = (cnt_reg == CNT_W'(CAPACITY));

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] left_v;
            logic [VALUE_WIDTH-1:0] right_v;

            if (gi == 0)
            begin : g_first
                assign left_v = cell_val[gi];
            end
            else
            begin : g_mid_l
                assign left_v = cell_val[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_v = cell_val[gi];
            end
            else
            begin : g_mid_r
                assign right_v = cell_val[gi+1];
            end

            ile_cell #(
                .IDX   (gi),
                .VW    (VALUE_WIDTH),
                .IDX_W (IDX_W)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .k           (k),
                .wr_value    (val_reg),
                .cmp_value   (in_val),
                .left_value  (left_v),
                .right_value (right_v),
                .value       (cell_val[gi]),
                .match       (cell_match[gi]),
                .read_part   (cell_rd[gi])
            );

            assign live[gi] = (CNT_W'(gi) < cnt_reg);
        end
    endgenerate

    always_comb
    begin
        read_all = '0;
        for (int i = 0; i < CAPACITY; i++)
            read_all = read_all | cell_rd[i];
    end

    ile_pick #(
        .N     (CAPACITY),
        .IDX_W (IDX_W)
    ) u_pick (
        .hits  (cell_match & live),
        .last  (command_t'(cmd_reg) == CMD_LAST_INDEX),
        .hit   (pick_hit),
        .index (pick_idx)
    );

    // command decoder for the execute cycle
    always_comb
    begin
        dec_op   = OP_HOLD;
        k        = pos_k;
        dec_st   = STAT_OK;
        dec_hit  = 1'b0;
        dec_rv   = '0;
        cnt_next = cnt_reg;
        unique case (command_t'(cmd_reg))
            CMD_APPEND:
            begin
                k = cnt_k;
                if (full)
                    dec_st = STAT_FULL;
                else
                begin
                    dec_op   = OP_INSERT;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            CMD_INSERT:
            begin
                if (pos_x > cnt_x)
                    dec_st = STAT_RANGE;
                else if (full)
                    dec_st = STAT_FULL;
                else
                begin
                    dec_op   = OP_INSERT;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE_AT:
            begin
                if (pos_x >= cnt_x)
                    dec_st = STAT_RANGE;
                else
                begin
                    dec_op   = OP_REMOVE;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            CMD_REMOVE_VALUE:
            begin
                k       = pick_idx;
                dec_hit = pick_hit;
                if (pick_hit)
                begin
                    dec_op   = OP_REMOVE;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                    dec_st = STAT_NOTFOUND;
            end
            CMD_GET:
            begin
                if (pos_x >= cnt_x)
                    dec_st = STAT_RANGE;
                else
                begin
                    for (int b = 0; b < VI_N; b++)
                        dec_rv[b] = read_all[b];
                end
            end
            CMD_SET:
            begin
                if (pos_x >= cnt_x)
                    dec_st = STAT_RANGE;
                else
                    dec_op = OP_WRITE;
            end
            CMD_FIRST_INDEX, CMD_LAST_INDEX:
            begin
                dec_hit = pick_hit;
                if (!pick_hit)
                    dec_st = STAT_NOTFOUND;
            end
            default:
            begin
                dec_op = OP_HOLD;
            end
        endcase
    end

    always_comb
    begin
        dec_fi = '0;
        dec_ec = '0;
        for (int b = 0; b < FI_N; b++)
            dec_fi[b] = dec_hit & pick_idx[b];
        for (int b = 0; b < FC_N; b++)
            dec_ec[b] = cnt_next[b];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state machine outputs
    always_comb
    begin
        req.ready   = 1'b0;
        load        = 1'b0;
        ctrl.op     = OP_HOLD;
        ctrl.cmp_en = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready   = !out_valid_reg || rsp.ready;
                ctrl.cmp_en = req.valid && req.ready;
            end
            S_EXEC:
            begin
                load    = 1'b1;
                ctrl.op = dec_op;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign accept = req.valid && req.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (load)
                cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.command;
            pos_reg <= req.position;
            val_reg <= in_val;
        end
        if (load)
        begin
            rv_reg <= dec_rv;
            fi_reg <= dec_fi;
            fd_reg <= dec_hit;
            ec_reg <= dec_ec;
            st_reg <= dec_st;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = rv_reg;
    assign rsp.found_index = fi_reg;
    assign rsp.found       = fd_reg;
    assign rsp.entry_count = ec_reg;
    assign rsp.status      = st_reg;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 out_valid_reg)
        else $error("result word missing two cycles after a command");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_moves_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> $past(state_reg == S_EXEC))
        else $error("entry count changed outside the execute cycle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !out_valid_reg)
        else $error("result register loaded while still holding a word");

endmodule

/* sim/indexed_list_engine_checker.sv */
// list checker: tracks every command word, predicts its result word and compares
`timescale 1ns / 1ps

module ile_list_checker
    import ile_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic clk,
    input  logic rst_n,
    ile_req_if   req,
    ile_rsp_if   rsp,
    output int   mismatches,
    output int   pending,
    output int   list_len
);

    typedef struct {
        logic [DATA_W-1:0] read_value;
        logic [FIDX_W-1:0] found_index;
        logic              found;
        logic [FCNT_W-1:0] entry_count;
        status_t           status;
    } list_result_t;

    logic [DATA_W-1:0] shadow_list [CAPACITY];
    int                shadow_len;
    list_result_t      result_q [$];
    int                fail_total;

    function automatic int find_value(input logic [DATA_W-1:0] val, input logic from_end);
        int hit_at;
        hit_at = -1;
        for (int i = 0; i < shadow_len; i++)
            if (shadow_list[i] == val && (from_end || hit_at < 0))
                hit_at = i;
        return hit_at;
    endfunction

    function automatic void drop_entry(input int at);
        for (int i = at; i + 1 < shadow_len; i++)
            shadow_list[i] = shadow_list[i + 1];
        shadow_len--;
    endfunction

    function automatic list_result_t apply_command(input command_t cmd,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [DATA_W-1:0] val);
        list_result_t r;
        int           hit_at;
        r.read_value  = '0;
        r.found_index = '0;
        r.found       = 1'b0;
        r.status      = STAT_OK;
        hit_at        = -1;
        case (cmd)
            CMD_APPEND:
                if (shadow_len >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    shadow_list[shadow_len] = val;
                    shadow_len++;
                end
            CMD_INSERT:
                if (int'(pos) > shadow_len)
                    r.status = STAT_RANGE;
                else if (shadow_len >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    for (int i = shadow_len; i > int'(pos); i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[pos] = val;
                    shadow_len++;
                end
            CMD_REMOVE_AT:
                if (int'(pos) >= shadow_len)
                    r.status = STAT_RANGE;
                else
                    drop_entry(pos);
            CMD_GET:
                if (int'(pos) >= shadow_len)
                    r.status = STAT_RANGE;
                else
                    r.read_value = shadow_list[pos];
            CMD_SET:
                if (int'(pos) >= shadow_len)
                    r.status = STAT_RANGE;
                else
                    shadow_list[pos] = val;
            default:
            begin
                // remove_value and both searches share the lookup
                hit_at = find_value(val, cmd == CMD_LAST_INDEX);
                if (hit_at < 0)
                    r.status = STAT_NOTFOUND;
                else
                begin
                    r.found       = 1'b1;
                    r.found_index = hit_at[FIDX_W-1:0];
                    if (cmd == CMD_REMOVE_VALUE)
                        drop_entry(hit_at);
                end
            end
        endcase
        r.entry_count = shadow_len[FCNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        list_result_t want;
        if (!rst_n)
        begin
            shadow_len = 0;
            result_q.delete();
            fail_total = 0;
        end
        else
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result word with no command outstanding");
                    fail_total++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (rsp.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %h, got %h", want.read_value, rsp.read_value);
                        fail_total++;
                    end
                    if (rsp.found_index !== want.found_index)
                    begin
                        $error("found_index: expected %0d, got %0d",
                               want.found_index, rsp.found_index);
                        fail_total++;
                    end
                    if (rsp.found !== want.found)
                    begin
                        $error("found: expected %b, got %b", want.found, rsp.found);
                        fail_total++;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, rsp.entry_count);
                        fail_total++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fail_total++;
                    end
                end
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
                result_q.push_back(apply_command(command_t'(req.command), req.position,
                                                 req.item_value));
        end
        mismatches <= fail_total;
        pending    <= result_q.size();
        list_len   <= shadow_len;
    end

endmodule

/* sim/indexed_list_engine_tb.sv */
// testbench top: clock, reset, command stimulus, result back-pressure and verdict
`timescale 1ns / 1ps

module indexed_list_engine_tb;
    import ile_pkg::*;

    localparam int LIST_CAPACITY = 64;
    localparam int RANDOM_WORDS  = 1525;
    localparam int STALL_LIMIT   = 1000;

    localparam logic [DATA_W-1:0] COMMON_VALUES [8] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h0000_00FF
    };

    logic clk = 1'b0;
    logic rst_n;
    logic quiet;
    int   mismatches;
    int   pending;
    int   list_len;
    int   stall_cycles;

    ile_req_if req_ch ();
    ile_rsp_if rsp_ch ();

    indexed_list_engine #(
        .CAPACITY    (LIST_CAPACITY),
        .VALUE_WIDTH (DATA_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ile_list_checker #(
        .CAPACITY (LIST_CAPACITY)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .pending    (pending),
        .list_len   (list_len)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side back-pressure, none during the quiet stretch
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic issue(input command_t cmd, input int pos, input logic [DATA_W-1:0] val);
        if (!quiet)
            while ($urandom_range(0, 99) < 16)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.position   <= pos[POS_W-1:0];
        req_ch.item_value <= val;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    initial
    begin
        int       roll;
        int       pos;
        int       phase;
        command_t cmd;
        logic [DATA_W-1:0] val;

        rst_n             = 1'b0;
        quiet             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_APPEND;
        req_ch.position   = '0;
        req_ch.item_value = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every positional access but insert at 0 and every search fails
        issue(CMD_GET,          0,   32'h0);
        issue(CMD_REMOVE_AT,    0,   32'h0);
        issue(CMD_SET,          0,   32'hDEAD_BEEF);
        issue(CMD_FIRST_INDEX,  0,   32'h0);
        issue(CMD_LAST_INDEX,   0,   32'h0);
        issue(CMD_REMOVE_VALUE, 0,   32'h0);
        issue(CMD_INSERT,       1,   32'h7);
        issue(CMD_INSERT,       0,   32'hFFFF_FFFF);
        issue(CMD_APPEND,       0,   32'h0);
        issue(CMD_APPEND,       0,   32'hFFFF_FFFF);
        issue(CMD_INSERT,       1,   32'h1234_5678);
        // insert at a position equal to the count lands at the end
        issue(CMD_INSERT,       4,   32'h0);
        issue(CMD_FIRST_INDEX,  0,   32'hFFFF_FFFF);
        issue(CMD_LAST_INDEX,   0,   32'hFFFF_FFFF);
        issue(CMD_FIRST_INDEX,  0,   32'h0);
        issue(CMD_LAST_INDEX,   0,   32'h0);
        issue(CMD_GET,          1,   32'h0);
        issue(CMD_SET,          127, 32'h1);
        issue(CMD_GET,          5,   32'h0);
        issue(CMD_SET,          0,   32'h0);
        issue(CMD_REMOVE_VALUE, 0,   32'h0);
        issue(CMD_REMOVE_AT,    3,   32'h0);
        issue(CMD_REMOVE_AT,    0,   32'h0);
        issue(CMD_GET,          64,  32'h0);
        issue(CMD_INSERT,       127, 32'h3);

        // phases of a hundred words: grow to full, churn, then drain
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            quiet <= (n >= 700 && n < 950);
            phase = (n / 100) % 3;
            roll  = $urandom_range(0, 99);
            if (phase == 0)
                cmd = (roll < 45) ? CMD_APPEND :
                      (roll < 80) ? CMD_INSERT : command_t'($urandom_range(2, 7));
            else if (phase == 2)
                cmd = (roll < 35) ? CMD_REMOVE_AT :
                      (roll < 65) ? CMD_REMOVE_VALUE : command_t'($urandom_range(0, 7));
            else
                cmd = command_t'($urandom_range(0, 7));
            roll = $urandom_range(0, 99);
            if (roll < 75)
                pos = $urandom_range(0, list_len);
            else if (roll < 85)
                pos = list_len;
            else
                pos = $urandom_range(0, 127);
            if ($urandom_range(0, 99) < 60)
                val = COMMON_VALUES[$urandom_range(0, 7)];
            else
                val = $urandom();
            issue(cmd, pos, val);
        end
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* indexed_list_engine.f */
hdl/ile_pkg.sv
hdl/ile_req_if.sv
hdl/ile_rsp_if.sv
hdl/ile_cell.sv
hdl/ile_pick.sv
hdl/indexed_list_engine.sv
sim/indexed_list_engine_checker.sv
sim/indexed_list_engine_tb.sv
